// ===== src/bounded_uniform_random_defines.svh =====
// Assertion macros for the bounded uniform random block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BOUNDED_UNIFORM_RANDOM_DEFINES_SVH
`define BOUNDED_UNIFORM_RANDOM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BUR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define BUR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/bur_pkg.sv =====
// Shared types, constants and tempering function for the bounded random block.
// No dependencies.
package bur_pkg;

    localparam int unsigned TW_N   = 312;
    localparam int unsigned TW_M   = 156;
    localparam int unsigned IDX_W  = 9;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [63:0]      word_t;

    localparam word_t TW_MATRIX   = 64'hB502_6F5A_A966_19E9;
    localparam word_t TW_UPPER    = 64'hFFFF_FFFF_8000_0000;
    localparam word_t TW_LOWER    = 64'h0000_0000_7FFF_FFFF;
    localparam word_t TW_INIT_MUL = 64'h5851_F42D_4C95_7F2D;
    localparam word_t RESET_SEED  = 64'h0A02_BDBF_7BB3_C0A7;
    localparam word_t SM_GAMMA    = 64'h9E37_79B9_7F4A_7C15;
    localparam word_t SM_MUL1     = 64'hBF58_476D_1CE4_E5B9;
    localparam word_t SM_MUL2     = 64'h94D0_49BB_1331_11EB;

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mul_req_t;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [127:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        word_t rem;
    } div_rsp_t;

    typedef struct packed {
        logic  we;
        idx_t  waddr;
        word_t wdata;
        idx_t  raddr;
    } mem_req_t;

    function automatic word_t temper(input word_t w);
        word_t x;
        x = w;
        x = x ^ ((x >> 29) & 64'h5555_5555_5555_5555);
        x = x ^ ((x << 17) & 64'h71D6_7FFF_EDA6_0000);
        x = x ^ ((x << 37) & 64'hFFF7_EEE0_0000_0000);
        x = x ^ (x >> 43);
        return x;
    endfunction

endpackage

// ===== src/bur_stream_if.sv =====
// Valid/ready channel interfaces for commands in and values out.
// Depends on bur_pkg for the word type.
interface bur_in_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    bur_pkg::word_t    bound;
    bur_pkg::word_t    seed;

    modport source (output valid, cmd, bound, seed, input ready);
    modport sink   (input valid, cmd, bound, seed, output ready);
endinterface

interface bur_out_if;
    logic              valid;
    logic              ready;
    bur_pkg::word_t    value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

// ===== src/bur_mem.sv =====
// Twister word store: one write port, one registered read port.
// Depends on bur_pkg.
module bur_mem (
    input  logic              clk,
    input  bur_pkg::mem_req_t req,
    output bur_pkg::word_t    rdata
);
    import bur_pkg::*;

    word_t mem [TW_N];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/bur_mul.sv =====
// Shared 64x64 multiplier built from one 32x32 multiplier over four steps.
// Depends on bur_pkg.
module bur_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  bur_pkg::mul_req_t req,
    output bur_pkg::mul_rsp_t rsp
);
    import bur_pkg::*;

    word_t        a_reg, b_reg;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [1:0]   k;
    logic [31:0]  a_half, b_half;

    assign k      = step_reg[1:0];
    assign a_half = k[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = k[0] ? b_reg[63:32] : b_reg[31:0];
    assign pp_next = {32'd0, a_half} * {32'd0, b_half};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    // Register each partial product, then accumulate it in the next cycle.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg != 3'd4)
            begin
                pp_reg <= pp_next;
                sh_reg <= {1'b0, k[0]} + {1'b0, k[1]};
            end
            if (step_reg != 3'd0)
            begin
                acc_reg <= acc_reg + ({64'd0, pp_reg} << {sh_reg, 5'd0});
            end
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;
endmodule

// ===== src/bur_div.sv =====
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on bur_pkg.
module bur_div (
    input  logic              clk,
    input  logic              rst_n,
    input  bur_pkg::div_req_t req,
    output bur_pkg::div_rsp_t rsp
);
    import bur_pkg::*;

    localparam int unsigned STEPS = 64;

    word_t       dvd_reg, dvs_reg, rem_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] sh;

    assign sh = {rem_reg, dvd_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            if (sh >= {1'b0, dvs_reg})
            begin
                rem_reg <= 64'(sh - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= sh[63:0];
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
endmodule

// ===== src/bounded_uniform_random.sv =====
// Bounded uniform random generator: MT19937-64 words reduced to [0, bound)
// by multiply-high with rejection.
// Channels: in_ch (cmd, bound, seed) and out_ch (value), valid/ready each.
// cmd = 0 draws one value below bound (bound 0 gives 0); cmd = 1 reseeds
// through splitmix64 and gives no result.
// A draw with nonzero bound reads one stored word per attempt; once all
// 312 words are used, the next draw first regenerates the whole store,
// one word at a time. A draw runs the remainder unit only the first time
// its low product half falls below bound. Each multiply runs on the shared
// 32x32 multiplier. A reseed runs two splitmix64 multiplies, then one per word.
// One item is in flight at a time: in_ch.ready is high only when idle.
// After reset the block fills the store from the default seed with
// in_ch.ready low, then waits for the first item.
// A finished value sits in the output register; a new item is accepted
// while it waits, and the next result holds until out_ch takes the first.
// Depends on bur_pkg, bur_stream_if, bur_mem, bur_mul, bur_div and
// bounded_uniform_random_defines.svh.
`include "bounded_uniform_random_defines.svh"

module bounded_uniform_random (
    input  logic      clk,
    input  logic      rst_n,
    bur_in_if.sink    in_ch,
    bur_out_if.source out_ch
);
    import bur_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_MIX1     = 15'b000000000000010,
        S_MIX2     = 15'b000000000000100,
        S_INIT_WR  = 15'b000000000001000,
        S_INIT_MUL = 15'b000000000010000,
        S_RG_ADDR0 = 15'b000000000100000,
        S_RG_A     = 15'b000000001000000,
        S_RG_B     = 15'b000000010000000,
        S_RG_W     = 15'b000000100000000,
        S_CHECK    = 15'b000001000000000,
        S_RD       = 15'b000010000000000,
        S_MUL      = 15'b000100000000000,
        S_DIV      = 15'b001000000000000,
        S_OUT      = 15'b010000000000000,
        S_SPARE    = 15'b100000000000000
    } state_t;

    localparam idx_t LAST_IDX = idx_t'(TW_N - 1);
    localparam idx_t N_IDX    = idx_t'(TW_N);
    localparam idx_t M_IDX    = idx_t'(TW_M);
    localparam idx_t NM_IDX   = idx_t'(TW_N - TW_M);

    state_t   state_reg, state_next;
    idx_t     widx_reg, widx_next;
    idx_t     cnt_reg, cnt_next;
    word_t    prev_reg, prev_next;
    word_t    nxt_reg, nxt_next;
    word_t    bound_reg, bound_next;
    word_t    thr_reg, thr_next;
    logic     thr_ok_reg, thr_ok_next;
    word_t    res_reg, res_next;
    logic     out_valid_reg, out_valid_next;
    word_t    out_value_reg, out_value_next;

    mem_req_t mem_req;
    word_t    rdata;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    word_t    sm_v, y, regen_v, p_lo, p_hi;
    logic     in_xfer;

    bur_mem u_mem (.clk(clk), .req(mem_req), .rdata(rdata));
    bur_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
    bur_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign in_xfer      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.value = out_value_reg;

    assign p_lo    = mul_rsp.product[63:0];
    assign p_hi    = mul_rsp.product[127:64];
    assign sm_v    = in_ch.seed + SM_GAMMA;
    assign y       = (prev_reg & TW_UPPER) | (nxt_reg & TW_LOWER);
    assign regen_v = rdata ^ (y >> 1) ^ (y[0] ? TW_MATRIX : 64'd0);

    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        bound_next     = bound_reg;
        thr_next       = thr_reg;
        thr_ok_next    = thr_ok_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        mem_req        = '{we: 1'b0, waddr: cnt_reg, wdata: prev_reg, raddr: widx_reg};
        mul_req        = '{start: 1'b0, a: prev_reg ^ (prev_reg >> 62), b: TW_INIT_MUL};
        div_req        = '{start: 1'b0, dividend: 64'd0 - bound_reg, divisor: bound_reg};

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_ch.cmd == CMD_RESEED)
                    begin
                        mul_req.start = 1'b1;
                        mul_req.a     = sm_v ^ (sm_v >> 30);
                        mul_req.b     = SM_MUL1;
                        state_next    = S_MIX1;
                    end
                    else
                    begin
                        bound_next  = in_ch.bound;
                        thr_ok_next = 1'b0;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_MIX1:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = p_lo ^ (p_lo >> 27);
                    mul_req.b     = SM_MUL2;
                    state_next    = S_MIX2;
                end
            end
            S_MIX2:
            begin
                if (mul_rsp.done)
                begin
                    prev_next  = p_lo ^ (p_lo >> 31);
                    cnt_next   = '0;
                    state_next = S_INIT_WR;
                end
            end
            S_INIT_WR:
            begin
                mem_req.we = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    widx_next  = N_IDX;
                    state_next = S_IDLE;
                end
                else
                begin
                    mul_req.start = 1'b1;
                    state_next    = S_INIT_MUL;
                end
            end
            S_INIT_MUL:
            begin
                if (mul_rsp.done)
                begin
                    prev_next  = p_lo + word_t'(cnt_reg) + 64'd1;
                    cnt_next   = cnt_reg + idx_t'(1);
                    state_next = S_INIT_WR;
                end
            end
            S_RG_ADDR0:
            begin
                mem_req.raddr = '0;
                cnt_next      = '0;
                state_next    = S_RG_A;
            end
            S_RG_A:
            begin
                if (cnt_reg == '0)
                begin
                    prev_next = rdata;
                end
                mem_req.raddr = (cnt_reg == LAST_IDX) ? '0 : cnt_reg + idx_t'(1);
                state_next    = S_RG_B;
            end
            S_RG_B:
            begin
                nxt_next      = rdata;
                mem_req.raddr = (cnt_reg < NM_IDX) ? cnt_reg + M_IDX : cnt_reg - NM_IDX;
                state_next    = S_RG_W;
            end
            S_RG_W:
            begin
                mem_req.we    = 1'b1;
                mem_req.wdata = regen_v;
                prev_next     = nxt_reg;
                if (cnt_reg == LAST_IDX)
                begin
                    widx_next  = '0;
                    state_next = S_CHECK;
                end
                else
                begin
                    cnt_next   = cnt_reg + idx_t'(1);
                    state_next = S_RG_A;
                end
            end
            S_CHECK:
            begin
                if (bound_reg == '0)
                begin
                    res_next   = '0;
                    state_next = S_OUT;
                end
                else if (widx_reg >= N_IDX)
                begin
                    state_next = S_RG_ADDR0;
                end
                else
                begin
                    mem_req.raddr = widx_reg;
                    state_next    = S_RD;
                end
            end
            S_RD:
            begin
                widx_next     = widx_reg + idx_t'(1);
                mul_req.start = 1'b1;
                mul_req.a     = temper(rdata);
                mul_req.b     = bound_reg;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                if (mul_rsp.done)
                begin
                    res_next = p_hi;
                    if (p_lo < bound_reg)
                    begin
                        if (!thr_ok_reg)
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                        else if (p_lo < thr_reg)
                        begin
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    thr_next    = div_rsp.rem;
                    thr_ok_next = 1'b1;
                    // Product is still held in the multiplier.
                    state_next  = (p_lo < div_rsp.rem) ? S_CHECK : S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT_WR;
            widx_reg      <= N_IDX;
            cnt_reg       <= '0;
            prev_reg      <= RESET_SEED;
            thr_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            cnt_reg       <= cnt_next;
            prev_reg      <= prev_next;
            thr_ok_reg    <= thr_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nxt_reg       <= nxt_next;
        bound_reg     <= bound_next;
        thr_reg       <= thr_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
    end

    `BUR_ASSERT_NOW(a_widx_range, 1'b1, widx_reg <= N_IDX)
    `BUR_ASSERT_NOW(a_accept_mul_idle, in_xfer, !mul_rsp.busy && !div_rsp.busy)
    `BUR_ASSERT_NEXT(a_out_load, (state_reg == S_OUT) && !out_valid_reg, out_valid_reg)
endmodule
